FILE: hdl/chmt_pkg.sv
// Shared constants for the cache hit/miss tracker.
package chmt_pkg;

  localparam int unsigned NUM_BLOCKS = 64;
  localparam int unsigned SLOT_W     = $clog2(NUM_BLOCKS);
  localparam int unsigned ADDR_W     = 32;
  localparam int unsigned CNT_W      = 32;
  localparam int unsigned PEN_W      = 48;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned LFSR_W     = 16;

  localparam logic [CFG_IDX_W-1:0] REG_ORGANISATION   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_BITS      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_BITS     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WRITE_ALLOCATE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_REPLACEMENT    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MISS_COST      = 3'd5;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_STORE = 1'b1;

  localparam logic ORG_DIRECT = 1'b0;
  localparam logic ORG_ASSOC  = 1'b1;

  localparam logic REPL_RANDOM = 1'b0;
  localparam logic REPL_AGE    = 1'b1;

  localparam logic [3:0]        LINE_BITS_MAX  = 4'd8;
  localparam logic [2:0]        BLOCK_BITS_MAX = 3'd6;
  localparam logic [LFSR_W-1:0] LFSR_SEED      = 16'hACE1;

endpackage

FILE: hdl/cache_hit_miss_tracker_unit.sv
// Cache hit/miss tracker: tag lookup, fill and statistics over tag and age memories.
//
// Each word takes one load or store address and returns one result word with
// hit, slot, allocation flag and the running saturating counters. Items are
// processed one at a time; a result may wait in the output register while the
// next word is accepted and worked on. Direct-mapped lookup steps through accept
// and tag read, compare and finish, with a fill step on an allocating miss. Fully
// associative lookup reads the tag memory one slot per cycle and compares up to
// the 2**block_bits slots in use; a fill with age replacement adds one pass over
// the age memory of the slots in use, a random fill takes its slot from the LFSR. The
// finish step repeats while the previous result still waits in the output register.
// No clearing pass follows reset.
module cache_hit_miss_tracker_unit
  import chmt_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  opcode_i,
  input  logic [ADDR_W-1:0]     address_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  hit_o,
  output logic [SLOT_W-1:0]     victim_slot_o,
  output logic                  allocated_o,
  output logic [CNT_W-1:0]      loads_seen_o,
  output logic [CNT_W-1:0]      load_hits_o,
  output logic [CNT_W-1:0]      stores_seen_o,
  output logic [CNT_W-1:0]      store_hits_o,
  output logic [PEN_W-1:0]      penalty_total_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DMCMP  = 3'd1;
  localparam logic [2:0] S_FASRCH = 3'd2;
  localparam logic [2:0] S_AGE    = 3'd3;
  localparam logic [2:0] S_FILL   = 3'd4;
  localparam logic [2:0] S_DONE   = 3'd5;

  logic [2:0]            state_q;

  logic                  org_q;
  logic [3:0]            line_bits_q;
  logic [2:0]            block_bits_q;
  logic                  write_alloc_q;
  logic                  repl_q;
  logic [15:0]           miss_cost_q;

  logic [ADDR_W-1:0]     tag_mem [NUM_BLOCKS];
  logic [ADDR_W-1:0]     tag_rdata_q;
  logic [SLOT_W-1:0]     tag_raddr;
  logic                  tag_we;

  logic [SLOT_W-1:0]     age_mem [NUM_BLOCKS];
  logic [SLOT_W-1:0]     age_rdata_q;
  logic [SLOT_W-1:0]     age_raddr;
  logic                  age_we;
  logic [NUM_BLOCKS-1:0] age_wr_q;
  logic [SLOT_W-1:0]     age_cur;
  logic [SLOT_W-1:0]     age_nxt;

  logic [NUM_BLOCKS-1:0] valid_q;
  logic [LFSR_W-1:0]     lfsr_q;
  logic [LFSR_W-1:0]     lfsr_nxt;

  logic                  store_q;
  logic [ADDR_W-1:0]     tag_q;
  logic [SLOT_W-1:0]     slot_q;
  logic [SLOT_W-1:0]     used_m1_q;
  logic [SLOT_W-1:0]     cmp_idx_q;
  logic [SLOT_W-1:0]     age_cnt_q;
  logic                  found_q;
  logic                  hit_q;
  logic                  alloc_q;

  logic [CNT_W-1:0]      loads_q;
  logic [CNT_W-1:0]      load_hits_q;
  logic [CNT_W-1:0]      stores_q;
  logic [CNT_W-1:0]      store_hits_q;
  logic [PEN_W-1:0]      pen_q;
  logic [PEN_W:0]        pen_sum;

  logic                  out_valid_q;
  logic                  out_hit_q;
  logic [SLOT_W-1:0]     out_slot_q;
  logic                  out_alloc_q;

  logic [3:0]            lb;
  logic [2:0]            bb;
  logic [4:0]            lbb;
  logic [SLOT_W-1:0]     used_m1;
  logic [SLOT_W-1:0]     dm_slot_in;
  logic [ADDR_W-1:0]     tag_in;
  logic                  in_fire;
  logic                  dm_hit;
  logic                  fa_match;
  logic                  fill_ok;
  logic                  commit;

  assign lb         = (line_bits_q > LINE_BITS_MAX) ? LINE_BITS_MAX : line_bits_q;
  assign bb         = (block_bits_q > BLOCK_BITS_MAX) ? BLOCK_BITS_MAX : block_bits_q;
  assign lbb        = {1'b0, lb} + {2'b00, bb};
  assign used_m1    = SLOT_W'((7'd1 << bb) - 7'd1);
  assign dm_slot_in = SLOT_W'(address_i >> lb) & used_m1;
  assign tag_in     = (org_q == ORG_ASSOC) ? (address_i >> lb) : (address_i >> lbb);

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign dm_hit     = valid_q[slot_q] && (tag_rdata_q == tag_q);
  assign fa_match   = valid_q[cmp_idx_q] && (tag_rdata_q == tag_q);
  assign fill_ok    = (store_q == OP_LOAD) || write_alloc_q;
  assign commit     = (state_q == S_DONE) && (!out_valid_q || out_ready_i);

  assign lfsr_nxt = {lfsr_q[0] ^ lfsr_q[2] ^ lfsr_q[3] ^ lfsr_q[5], lfsr_q[LFSR_W-1:1]};

  assign age_cur = age_wr_q[age_cnt_q] ? age_rdata_q : age_cnt_q;
  assign age_nxt = (age_cur == '0) ? used_m1_q : age_cur - SLOT_W'(1);
  assign age_we  = (state_q == S_AGE);
  assign tag_we  = (state_q == S_FILL);

  assign pen_sum = {1'b0, pen_q} + (PEN_W + 1)'(miss_cost_q);

  always_comb begin
    tag_raddr = '0;
    age_raddr = '0;
    case (state_q)
      S_IDLE: begin
        tag_raddr = (org_q == ORG_ASSOC) ? '0 : dm_slot_in;
      end
      S_FASRCH: begin
        tag_raddr = cmp_idx_q + SLOT_W'(1);
      end
      S_AGE: begin
        age_raddr = age_cnt_q + SLOT_W'(1);
      end
      default: begin
        tag_raddr = '0;
        age_raddr = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (tag_we) begin
      tag_mem[slot_q] <= tag_q;
    end
    tag_rdata_q <= tag_mem[tag_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (age_we) begin
      age_mem[age_cnt_q] <= age_nxt;
    end
    age_rdata_q <= age_mem[age_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      org_q         <= ORG_DIRECT;
      line_bits_q   <= 4'd2;
      block_bits_q  <= 3'd6;
      write_alloc_q <= 1'b1;
      repl_q        <= REPL_AGE;
      miss_cost_q   <= 16'd100;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_ORGANISATION:   org_q         <= cfg_wdata_i[0];
        REG_LINE_BITS:      line_bits_q   <= cfg_wdata_i[3:0];
        REG_BLOCK_BITS:     block_bits_q  <= cfg_wdata_i[2:0];
        REG_WRITE_ALLOCATE: write_alloc_q <= cfg_wdata_i[0];
        REG_REPLACEMENT:    repl_q        <= cfg_wdata_i[0];
        REG_MISS_COST:      miss_cost_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      valid_q      <= '0;
      age_wr_q     <= '0;
      lfsr_q       <= LFSR_SEED;
      store_q      <= OP_LOAD;
      tag_q        <= '0;
      slot_q       <= '0;
      used_m1_q    <= '0;
      cmp_idx_q    <= '0;
      age_cnt_q    <= '0;
      found_q      <= 1'b0;
      hit_q        <= 1'b0;
      alloc_q      <= 1'b0;
      loads_q      <= '0;
      load_hits_q  <= '0;
      stores_q     <= '0;
      store_hits_q <= '0;
      pen_q        <= '0;
      out_valid_q  <= 1'b0;
      out_hit_q    <= 1'b0;
      out_slot_q   <= '0;
      out_alloc_q  <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i && !commit) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            store_q   <= opcode_i;
            tag_q     <= tag_in;
            used_m1_q <= used_m1;
            cmp_idx_q <= '0;
            hit_q     <= 1'b0;
            alloc_q   <= 1'b0;
            slot_q    <= (org_q == ORG_ASSOC) ? '0 : dm_slot_in;
            state_q   <= (org_q == ORG_ASSOC) ? S_FASRCH : S_DMCMP;
          end
        end
        S_DMCMP: begin
          hit_q   <= dm_hit;
          state_q <= (!dm_hit && fill_ok) ? S_FILL : S_DONE;
        end
        S_FASRCH: begin
          if (fa_match) begin
            hit_q   <= 1'b1;
            slot_q  <= cmp_idx_q;
            state_q <= S_DONE;
          end else if (cmp_idx_q == used_m1_q) begin
            if (!fill_ok) begin
              state_q <= S_DONE;
            end else if (repl_q == REPL_AGE) begin
              age_cnt_q <= '0;
              found_q   <= 1'b0;
              state_q   <= S_AGE;
            end else begin
              lfsr_q  <= lfsr_nxt;
              slot_q  <= SLOT_W'(lfsr_nxt) & used_m1_q;
              state_q <= S_FILL;
            end
          end else begin
            cmp_idx_q <= cmp_idx_q + SLOT_W'(1);
          end
        end
        S_AGE: begin
          age_wr_q[age_cnt_q] <= 1'b1;
          if ((age_cur == '0) && !found_q) begin
            found_q <= 1'b1;
            slot_q  <= age_cnt_q;
          end
          if (age_cnt_q == used_m1_q) begin
            state_q <= S_FILL;
          end else begin
            age_cnt_q <= age_cnt_q + SLOT_W'(1);
          end
        end
        S_FILL: begin
          valid_q[slot_q] <= 1'b1;
          alloc_q         <= 1'b1;
          state_q         <= S_DONE;
        end
        S_DONE: begin
          if (commit) begin
            if (store_q == OP_STORE) begin
              if (stores_q != '1) stores_q <= stores_q + CNT_W'(1);
              if (hit_q && (store_hits_q != '1)) store_hits_q <= store_hits_q + CNT_W'(1);
            end else begin
              if (loads_q != '1) loads_q <= loads_q + CNT_W'(1);
              if (hit_q && (load_hits_q != '1)) load_hits_q <= load_hits_q + CNT_W'(1);
            end
            if (!hit_q) begin
              pen_q <= pen_sum[PEN_W] ? '1 : pen_sum[PEN_W-1:0];
            end
            out_valid_q <= 1'b1;
            out_hit_q   <= hit_q;
            out_slot_q  <= slot_q;
            out_alloc_q <= alloc_q;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o     = out_valid_q;
  assign hit_o           = out_hit_q;
  assign victim_slot_o   = out_slot_q;
  assign allocated_o     = out_alloc_q;
  assign loads_seen_o    = loads_q;
  assign load_hits_o     = load_hits_q;
  assign stores_seen_o   = stores_q;
  assign store_hits_o    = store_hits_q;
  assign penalty_total_o = pen_q;

  a_hit_no_alloc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(hit_o && allocated_o))
    else $error("result reports both hit and allocation");

  a_commit_loads_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |=> out_valid_q && (state_q == S_IDLE))
    else $error("committed word not presented");

  a_search_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FASRCH) |-> (cmp_idx_q <= used_m1_q))
    else $error("tag sweep past slots in use");

  a_age_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_AGE) |-> (age_cnt_q <= used_m1_q))
    else $error("age sweep past slots in use");

  a_hits_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_hits_q <= loads_q) && (store_hits_q <= stores_q))
    else $error("hit counter exceeds access counter");

endmodule
